/* rtl/task_record_line_parser_macros.svh */
// Assertion macros shared by the task record line parser modules.
`ifndef TASK_RECORD_LINE_PARSER_MACROS_SVH
`define TASK_RECORD_LINE_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define TLP_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define TLP_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define TLP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TLP_ASSERT_HOLDS(lbl, expr, msg)
`define TLP_ASSERT_IMPLIES(lbl, pre, post, msg)
`define TLP_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

/* rtl/tlp_pkg.sv */
// Types, codes and constants shared by the task record line parser.
`default_nettype none
package tlp_pkg;

  localparam int MAX_TITLE_DEF = 64;
  localparam int MAX_DEPS_DEF  = 16;

  localparam int OUT_DATA_W = 56;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    KIND_ID    = 3'd0,
    KIND_DUR   = 3'd1,
    KIND_CNT   = 3'd2,
    KIND_DEP   = 3'd3,
    KIND_TITLE = 3'd4,
    KIND_END   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BLANK     = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef struct packed {
    logic clear;
    logic feed;
  } num_ctl_t;

  typedef struct packed {
    logic [2:0]            kind;
    logic [OUT_DATA_W-1:0] data;
  } out_item_t;

endpackage
`default_nettype wire

/* rtl/task_record_line_parser.sv */
// Task record line parser: one byte per item in, field, title and record-end items out.
// A result is registered into the output stage at the accepting edge while that stage is free.
// Throughput: one byte per cycle while skid is empty; phase and accumulator update each cycle.
// Register plus skid entry: a stalled result goes to the skid, input then waits until it moves.
// Reset: synchronous, active low; clears the parse state and output valids, no clearing pass.
`default_nettype none
`include "task_record_line_parser_macros.svh"
module task_record_line_parser #(
  parameter int MAX_TITLE = tlp_pkg::MAX_TITLE_DEF,
  parameter int MAX_DEPS  = tlp_pkg::MAX_DEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // char_code[7:0]
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [tlp_pkg::OUT_DATA_W-1:0] out_tdata, // field_value[31:0], dep_position[35:32],
                                                    // title_char[43:36], record_status[45:44],
                                                    // title_truncated[46], title_length[52:47],
                                                    // zero[55:53]
  output logic [2:0]       out_tuser   // out_kind[2:0]
);

  localparam int TL_W  = (MAX_TITLE > 2) ? $clog2(MAX_TITLE) : 1;
  localparam int DEP_W = $clog2(MAX_DEPS + 1);
  localparam logic [TL_W-1:0] TITLE_KEEP = TL_W'(MAX_TITLE - 1);

  typedef enum logic [2:0] {PH_ID, PH_DUR, PH_CNT, PH_DEP, PH_TTL} phase_t;

  phase_t            phase_r, phase_nxt;
  logic [TL_W-1:0]   tlen_r, tlen_nxt;
  logic [DEP_W-1:0]  seen_r, seen_nxt;
  logic [DEP_W-1:0]  exp_r, exp_nxt;
  logic              cinv_r, cinv_nxt;
  logic              ovf_r, ovf_nxt;

  tlp_pkg::num_ctl_t  num_ctl;
  logic signed [31:0] num_value;
  logic               num_started;

  logic               fire, eol, blank, skid_full;
  logic               res_v;
  tlp_pkg::kind_t     res_kind;
  logic [31:0]        res_value;
  logic [3:0]         res_pos;
  logic [7:0]         res_char;
  tlp_pkg::status_t   res_status;
  logic               res_trunc;
  logic [5:0]         res_len;
  tlp_pkg::out_item_t res_item, out_item;
  logic [DEP_W-1:0]   seen_inc;

  assign in_tready = !skid_full;
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    eol      = in_tlast || (in_tdata == tlp_pkg::CH_LF);
    blank    = in_tdata inside {tlp_pkg::CH_SP, tlp_pkg::CH_TAB, tlp_pkg::CH_CR,
                                tlp_pkg::CH_VT, tlp_pkg::CH_FF};
    seen_inc = seen_r + DEP_W'(1);

    phase_nxt = phase_r;
    tlen_nxt  = tlen_r;
    seen_nxt  = seen_r;
    exp_nxt   = exp_r;
    cinv_nxt  = cinv_r;
    ovf_nxt   = ovf_r;
    num_ctl   = '0;

    res_v      = 1'b0;
    res_kind   = tlp_pkg::KIND_ID;
    res_value  = '0;
    res_pos    = '0;
    res_char   = '0;
    res_status = tlp_pkg::ST_OK;
    res_trunc  = 1'b0;
    res_len    = '0;

    if (fire) begin
      if (eol) begin
        res_v    = 1'b1;
        res_kind = tlp_pkg::KIND_END;
        if (phase_r == PH_TTL && !cinv_r) begin
          res_status = tlp_pkg::ST_OK;
          res_trunc  = ovf_r;
          res_len    = 6'(tlen_r);
        end else if (phase_r == PH_ID) begin
          res_status = tlp_pkg::ST_BLANK;
        end else begin
          res_status = tlp_pkg::ST_MALFORMED;
        end
        // record end returns the parse state and the number accumulator to the reset state
        phase_nxt     = PH_ID;
        tlen_nxt      = '0;
        seen_nxt      = '0;
        exp_nxt       = '0;
        cinv_nxt      = 1'b0;
        ovf_nxt       = 1'b0;
        num_ctl.clear = 1'b1;
      end else if (phase_r == PH_TTL) begin
        if (!(blank && tlen_r == '0)) begin
          if (tlen_r < TITLE_KEEP) begin
            tlen_nxt = tlen_r + TL_W'(1);
            res_v    = 1'b1;
            res_kind = tlp_pkg::KIND_TITLE;
            res_char = in_tdata;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end else if (!blank) begin
        num_ctl.feed = 1'b1;
      end else if (num_started) begin
        num_ctl.clear = 1'b1;
        res_value     = num_value;
        case (phase_r)
          PH_ID: begin
            res_v     = 1'b1;
            res_kind  = tlp_pkg::KIND_ID;
            phase_nxt = PH_DUR;
          end
          PH_DUR: begin
            res_v     = 1'b1;
            res_kind  = tlp_pkg::KIND_DUR;
            phase_nxt = PH_CNT;
          end
          PH_CNT: begin
            res_v    = 1'b1;
            res_kind = tlp_pkg::KIND_CNT;
            if (num_value[31] || ($unsigned(num_value) > 32'(MAX_DEPS))) begin
              cinv_nxt  = 1'b1;
              phase_nxt = PH_DEP;
            end else if (num_value == 32'sd0) begin
              phase_nxt = PH_TTL;
            end else begin
              exp_nxt   = DEP_W'(num_value);
              seen_nxt  = '0;
              phase_nxt = PH_DEP;
            end
          end
          PH_DEP: begin
            // an invalid count leaves the rest of the line parsed silently
            if (!cinv_r) begin
              res_v    = 1'b1;
              res_kind = tlp_pkg::KIND_DEP;
              res_pos  = 4'(seen_r);
              seen_nxt = seen_inc;
              if (seen_inc >= exp_r) begin
                phase_nxt = PH_TTL;
              end
            end
          end
          default: begin
            phase_nxt = PH_ID;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID;
      tlen_r  <= '0;
      seen_r  <= '0;
      exp_r   <= '0;
      cinv_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      tlen_r  <= tlen_nxt;
      seen_r  <= seen_nxt;
      exp_r   <= exp_nxt;
      cinv_r  <= cinv_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  tlp_num u_num (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (num_ctl),
    .char_code (in_tdata),
    .value     (num_value),
    .started   (num_started)
  );

  assign res_item.kind = res_kind;
  assign res_item.data = {3'b000, res_len, res_trunc, res_status, res_char, res_pos, res_value};

  tlp_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_v),
    .push_item  (res_item),
    .full       (skid_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (out_item)
  );

  assign out_tdata = out_item.data;
  assign out_tuser = out_item.kind;

  `TLP_ASSERT_HOLDS(a_title_bound, tlen_r <= TITLE_KEEP, "title length past storage")
  `TLP_ASSERT_IMPLIES(a_dep_pending, phase_r == PH_DEP && !cinv_r, seen_r < exp_r, "dependency count overrun")
  `TLP_ASSERT_IMPLIES(a_invalid_in_dep, cinv_r, phase_r == PH_DEP, "invalid count outside dependency phase")

endmodule
`default_nettype wire

/* rtl/tlp_num.sv */
// Number token accumulator: sign, decimal digits, saturation to 32 bits.
`default_nettype none
module tlp_num (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tlp_pkg::num_ctl_t ctl,
  input  wire logic [7:0]        char_code,
  output logic signed [31:0]     value,
  output logic                   started
);

  logic [31:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic        stop_r, stop_nxt;
  logic        start_r, start_nxt;
  logic [35:0] prod;
  logic        is_digit;

  always_comb begin
    is_digit = char_code inside {[tlp_pkg::CH_ZERO:tlp_pkg::CH_NINE]};
    prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
         + 36'(char_code - tlp_pkg::CH_ZERO);
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    stop_nxt  = stop_r;
    start_nxt = start_r;
    if (ctl.clear) begin
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      stop_nxt  = 1'b0;
      start_nxt = 1'b0;
    end else if (ctl.feed) begin
      start_nxt = 1'b1;
      if (!stop_r) begin
        if (!start_r && (char_code == tlp_pkg::CH_PLUS || char_code == tlp_pkg::CH_MINUS)) begin
          neg_nxt = (char_code == tlp_pkg::CH_MINUS);
        end else if (is_digit) begin
          // magnitude held at 2^31 once reached; enough for both signs
          acc_nxt = (prod >= {4'b0, tlp_pkg::MAG_LIMIT}) ? tlp_pkg::MAG_LIMIT : prod[31:0];
        end else begin
          stop_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      neg_r   <= 1'b0;
      stop_r  <= 1'b0;
      start_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      stop_r  <= stop_nxt;
      start_r <= start_nxt;
    end
  end

  always_comb begin
    if (neg_r) begin
      value = acc_r[31] ? tlp_pkg::MAG_LIMIT : (32'd0 - acc_r);
    end else begin
      value = acc_r[31] ? tlp_pkg::POS_MAX : acc_r;
    end
  end

  assign started = start_r;

endmodule
`default_nettype wire

/* rtl/tlp_out_skid.sv */
// Output register with one skid entry that holds a result pushed during a stall.
`default_nettype none
`include "task_record_line_parser_macros.svh"
module tlp_out_skid (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire tlp_pkg::out_item_t push_item,
  output logic                    full,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output tlp_pkg::out_item_t      out_item
);

  logic               out_v_r, out_v_nxt;
  logic               skid_v_r, skid_v_nxt;
  tlp_pkg::out_item_t out_d_r, out_d_nxt;
  tlp_pkg::out_item_t skid_d_r, skid_d_nxt;
  logic               drain;

  always_comb begin
    drain      = !out_v_r || out_tready;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      // no push possible while the skid entry is taken
      if (out_tready) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (drain) begin
        out_d_nxt = push_item;
        out_v_nxt = 1'b1;
      end else begin
        skid_d_nxt = push_item;
        skid_v_nxt = 1'b1;
      end
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign full       = skid_v_r;
  assign out_tvalid = out_v_r;
  assign out_item   = out_d_r;

  `TLP_ASSERT_IMPLIES(a_skid_behind_out, skid_v_r, out_v_r, "skid entry held with empty output")
  `TLP_ASSERT_NEXT(a_stall_fills_skid, push && out_v_r && !out_tready && !skid_v_r, skid_v_r, "item lost on stall")

endmodule
`default_nettype wire
